// ===== rtl/bma_pkg.sv =====
`timescale 1ns / 1ps
package bma_pkg;

   localparam int MAP_BITS  = 1024;
   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W    = $clog2(NUM_WORDS);
   localparam int BPOS_W    = $clog2(WORD_BITS);
   localparam int IDX_W     = 10;
   localparam int CNT_W     = 11;
   localparam int NW_W      = WIDX_W + 1;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WIDX_W-1:0]    widx_type;
   typedef logic [BPOS_W-1:0]    bpos_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef logic [2:0] opcode_type;

   localparam opcode_type OP_SET       = 3'd0;
   localparam opcode_type OP_CLEAR     = 3'd1;
   localparam opcode_type OP_TOGGLE    = 3'd2;
   localparam opcode_type OP_FIND_CLR  = 3'd3;
   localparam opcode_type OP_FIND_SET  = 3'd4;
   localparam opcode_type OP_CLEAR_ALL = 3'd5;
   localparam opcode_type OP_SET_ALL   = 3'd6;

   localparam idx_type NOT_FOUND = '1;
   localparam cnt_type MAP_SIZE  = CNT_W'(MAP_BITS);

   // word unit result: in-use mask of the word, and the highest candidate bit
   typedef struct packed {
      logic     hit;
      bpos_type bit_pos;
      word_type mask;
   } scan_type;

endpackage

// ===== rtl/bma_map.sv =====
`timescale 1ns / 1ps
module bma_map (
   input  logic               clock,
   input  logic               reset,
   input  logic               clr_all,
   input  logic               wr_en,
   input  bma_pkg::widx_type  wr_addr,
   input  bma_pkg::word_type  wr_data,
   input  bma_pkg::widx_type  rd_addr,
   output bma_pkg::word_type  rd_data
);

   bma_pkg::word_type words_ff [bma_pkg::NUM_WORDS];

   always_ff @(posedge clock) begin
      if (reset || clr_all) begin
         for (int i = 0; i < bma_pkg::NUM_WORDS; i++) begin
            words_ff[i] <= '0;
         end
      end else if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = words_ff[rd_addr];

endmodule

// ===== rtl/bma_word_unit.sv =====
`timescale 1ns / 1ps
module bma_word_unit (
   input  bma_pkg::word_type  word,
   input  logic               want_set,
   input  bma_pkg::widx_type  word_idx,
   input  bma_pkg::cnt_type   size,
   output bma_pkg::scan_type  scan
);

   bma_pkg::cnt_type  base;
   bma_pkg::cnt_type  diff;
   bma_pkg::word_type mask;
   bma_pkg::word_type cand;
   bma_pkg::bpos_type pos;

   assign base = {1'b0, word_idx, bma_pkg::BPOS_W'(0)};
   assign diff = size - base;

   always_comb begin
      if (base >= size) begin
         mask = '0;
      end else if (diff >= bma_pkg::CNT_W'(bma_pkg::WORD_BITS)) begin
         mask = '1;
      end else begin
         // partial last word: keep the low diff bits
         mask = {bma_pkg::WORD_BITS{1'b1}} >>
                ((bma_pkg::BPOS_W+1)'(bma_pkg::WORD_BITS) - diff[bma_pkg::BPOS_W:0]);
      end
   end

   assign cand = (want_set ? word : ~word) & mask;

   always_comb begin
      pos = '0;
      for (int i = 0; i < bma_pkg::WORD_BITS; i++) begin
         if (cand[i]) begin
            pos = bma_pkg::BPOS_W'(i);
         end
      end
   end

   assign scan.hit     = |cand;
   assign scan.bit_pos = pos;
   assign scan.mask    = mask;

endmodule

// ===== rtl/bitmap_allocator_with_hints.sv =====
`timescale 1ns / 1ps
// Bitmap of 1024 bits kept as 32 words of 32 bits, with a set-bit count and
// last-set / last-cleared hints.
// Request channel: a request (req_opcode, req_bit_index) is taken on a clock
// edge with start high and busy low. busy stays high until the result is out.
// Result channel: rsp_valid is high for one cycle with rsp_result_index,
// rsp_found, rsp_prior_bit and rsp_count_after. There is no back-pressure;
// the receiver must take it in that cycle.
// CSR channel: csr_size_in_use is written when csr_valid and csr_ready are high
// (csr_ready is always high). Write it only while the block is idle.
// Steps, request edge to result strobe:
//   set / clear / toggle through the bit state; clear-all / unused code through the misc state
//   find: N words examined (1..32), one word per cycle through
//         the shared word mask / priority-encode unit
//   set-all: all 32 words written, one word per cycle
// A new request may be taken in the cycle the result strobe is high.
// Reset clears the map, count and hints and sets size_in_use to 1024.
module bitmap_allocator_with_hints (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_opcode,
   input  logic [9:0]            req_bit_index,
   output logic                  rsp_valid,
   output logic [9:0]            rsp_result_index,
   output logic                  rsp_found,
   output logic                  rsp_prior_bit,
   output logic [10:0]           rsp_count_after,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [10:0]           csr_size_in_use
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BIT  = 3'd1;
   localparam logic [2:0] ST_SCAN = 3'd2;
   localparam logic [2:0] ST_FILL = 3'd3;
   localparam logic [2:0] ST_MISC = 3'd4;

   logic [2:0]               state_ff, state_in;
   bma_pkg::opcode_type      op_ff, op_in;
   bma_pkg::idx_type         idx_ff, idx_in;
   bma_pkg::cnt_type         size_ff, size_in;   // eff size latched per request
   bma_pkg::widx_type        w_ff, w_in;
   logic [bma_pkg::NW_W-1:0] n_ff, n_in;
   bma_pkg::cnt_type         csr_size_ff;
   bma_pkg::cnt_type         ones_ff, ones_in;
   bma_pkg::cnt_type         last_set_ff, last_set_in;
   bma_pkg::cnt_type         last_clr_ff, last_clr_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   bma_pkg::idx_type         rsp_index_ff, rsp_index_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic                     rsp_prior_ff, rsp_prior_in;
   bma_pkg::cnt_type         rsp_count_ff, rsp_count_in;

   logic                     map_clr;
   logic                     map_wr;
   bma_pkg::widx_type        map_rd_addr;
   bma_pkg::word_type        map_wr_data;
   bma_pkg::word_type        map_rd_data;
   bma_pkg::scan_type        scan;

   bma_pkg::cnt_type         eff_size;
   bma_pkg::cnt_type         hint;
   logic [bma_pkg::NW_W-1:0] num_words;
   logic [bma_pkg::NW_W-1:0] w_next;
   logic                     scan_last;
   logic                     cur_bit;
   logic                     in_range;
   logic                     do_flip;
   bma_pkg::cnt_type         nw_sum;

   assign eff_size  = (csr_size_ff > bma_pkg::MAP_SIZE) ? bma_pkg::MAP_SIZE : csr_size_ff;
   assign hint      = (req_opcode == bma_pkg::OP_FIND_SET) ? last_set_ff : last_clr_ff;
   assign nw_sum    = size_ff + bma_pkg::CNT_W'(bma_pkg::WORD_BITS - 1);
   assign num_words = nw_sum[bma_pkg::CNT_W-1:bma_pkg::BPOS_W];
   assign w_next    = {1'b0, w_ff} + bma_pkg::NW_W'(1);
   // also true when the size is zero, so an empty map ends after one look
   assign scan_last = (n_ff + bma_pkg::NW_W'(1)) >= num_words;

   assign map_rd_addr = (state_ff == ST_BIT) ? idx_ff[bma_pkg::IDX_W-1:bma_pkg::BPOS_W] : w_ff;
   assign cur_bit     = map_rd_data[idx_ff[bma_pkg::BPOS_W-1:0]];
   assign in_range    = {1'b0, idx_ff} < size_ff;
   assign do_flip     = in_range && (((op_ff == bma_pkg::OP_SET) && !cur_bit) ||
                                     ((op_ff == bma_pkg::OP_CLEAR) && cur_bit) ||
                                     (op_ff == bma_pkg::OP_TOGGLE));

   bma_map u_map (
      .clock   (clock),
      .reset   (reset),
      .clr_all (map_clr),
      .wr_en   (map_wr),
      .wr_addr (map_rd_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   bma_word_unit u_word (
      .word     (map_rd_data),
      .want_set (op_ff == bma_pkg::OP_FIND_SET),
      .word_idx (w_ff),
      .size     (size_ff),
      .scan     (scan)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      size_in      = size_ff;
      w_in         = w_ff;
      n_in         = n_ff;
      ones_in      = ones_ff;
      last_set_in  = last_set_ff;
      last_clr_in  = last_clr_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_found_in = rsp_found_ff;
      rsp_prior_in = rsp_prior_ff;
      rsp_count_in = rsp_count_ff;
      map_clr      = 1'b0;
      map_wr       = 1'b0;
      map_wr_data  = map_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in   = req_opcode;
               idx_in  = req_bit_index;
               size_in = eff_size;
               n_in    = '0;
               w_in    = '0;
               case (req_opcode)
                  bma_pkg::OP_SET, bma_pkg::OP_CLEAR, bma_pkg::OP_TOGGLE: begin
                     state_in = ST_BIT;
                  end
                  bma_pkg::OP_FIND_CLR, bma_pkg::OP_FIND_SET: begin
                     state_in = ST_SCAN;
                     if (hint < eff_size) begin
                        w_in = hint[bma_pkg::IDX_W-1:bma_pkg::BPOS_W];
                     end
                  end
                  bma_pkg::OP_SET_ALL: begin
                     state_in = ST_FILL;
                  end
                  default: begin
                     state_in = ST_MISC;
                  end
               endcase
            end
         end
         ST_BIT: begin
            if (do_flip) begin
               map_wr      = 1'b1;
               map_wr_data = map_rd_data ^
                             (bma_pkg::word_type'(1) << idx_ff[bma_pkg::BPOS_W-1:0]);
               if (cur_bit) begin
                  ones_in     = ones_ff - bma_pkg::CNT_W'(1);
                  last_clr_in = {1'b0, idx_ff};
               end else begin
                  ones_in     = ones_ff + bma_pkg::CNT_W'(1);
                  last_set_in = {1'b0, idx_ff};
               end
            end
            rsp_valid_in = 1'b1;
            rsp_index_in = idx_ff;
            rsp_found_in = in_range;
            rsp_prior_in = in_range && cur_bit;
            rsp_count_in = ones_in;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            n_in = n_ff + bma_pkg::NW_W'(1);
            w_in = (w_next >= num_words) ? '0 : w_next[bma_pkg::WIDX_W-1:0];
            if (scan.hit || scan_last) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = scan.hit ? {w_ff, scan.bit_pos} : bma_pkg::NOT_FOUND;
               rsp_found_in = scan.hit;
               rsp_prior_in = 1'b0;
               rsp_count_in = ones_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_FILL: begin
            map_wr      = 1'b1;
            map_wr_data = scan.mask;
            w_in        = w_ff + bma_pkg::WIDX_W'(1);
            if (w_ff == bma_pkg::WIDX_W'(bma_pkg::NUM_WORDS - 1)) begin
               ones_in      = size_ff;
               last_set_in  = size_ff;
               last_clr_in  = size_ff;
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               rsp_found_in = 1'b0;
               rsp_prior_in = 1'b0;
               rsp_count_in = size_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_MISC: begin
            if (op_ff == bma_pkg::OP_CLEAR_ALL) begin
               map_clr     = 1'b1;
               ones_in     = '0;
               last_set_in = '0;
               last_clr_in = '0;
            end
            rsp_valid_in = 1'b1;
            rsp_index_in = '0;
            rsp_found_in = 1'b0;
            rsp_prior_in = 1'b0;
            rsp_count_in = ones_in;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_size_ff  <= bma_pkg::MAP_SIZE;
         ones_ff      <= '0;
         last_set_ff  <= '0;
         last_clr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ones_ff      <= ones_in;
         last_set_ff  <= last_set_in;
         last_clr_ff  <= last_clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            csr_size_ff <= csr_size_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      size_ff      <= size_in;
      w_ff         <= w_in;
      n_ff         <= n_in;
      rsp_index_ff <= rsp_index_in;
      rsp_found_ff <= rsp_found_in;
      rsp_prior_ff <= rsp_prior_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_prior_bit    = rsp_prior_ff;
   assign rsp_count_after  = rsp_count_ff;

endmodule

// ===== rtl/bma_checker.sv =====
`timescale 1ns / 1ps
module bma_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_found,
   input logic        rsp_prior_bit,
   input logic [10:0] rsp_count_after
);

   // an accepted request raises busy in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request taken but busy not raised");

   // the result comes out as the block returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // one result per request, so the result strobe is never high in back-to-back cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe on consecutive cycles");

   // a prior bit of one only comes from an in-range bit operation
   a_prior_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_prior_bit |-> rsp_found)
      else $error("prior bit set without found");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count_after <= 11'd1024)
      else $error("count above map size");

endmodule

bind bitmap_allocator_with_hints bma_checker u_bma_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_found       (rsp_found),
   .rsp_prior_bit   (rsp_prior_bit),
   .rsp_count_after (rsp_count_after)
);
